FILE: sv/scd_pkg.sv
// scd_pkg: constants and types for the scan code set 1 key decoder
// prefixes, scan codes, flag bit positions, special key ids and the result record
// no dependencies
package scd_pkg;

    // prefixes in the high byte of a raw word
    localparam logic [7:0] PRE_NONE  = 8'h00;
    localparam logic [7:0] PRE_EXT   = 8'hE0;
    localparam logic [7:0] PRE_PAUSE = 8'hFF;

    // unprefixed make codes
    localparam logic [7:0] SC_CTRL   = 8'h1D;
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_ALT    = 8'h38;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_NUM    = 8'h45;
    localparam logic [7:0] SC_SCROLL = 8'h46;

    // break codes
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_ALT_BRK    = 8'hB8;

    // extended codes after E0
    localparam logic [7:0] SC_ENTER  = 8'h1C;
    localparam logic [7:0] SC_PRINT  = 8'h37;
    localparam logic [7:0] SC_SLASH  = 8'h35;
    localparam logic [7:0] SC_HOME   = 8'h47;
    localparam logic [7:0] SC_UP     = 8'h48;
    localparam logic [7:0] SC_PGUP   = 8'h49;
    localparam logic [7:0] SC_LEFT   = 8'h4B;
    localparam logic [7:0] SC_RIGHT  = 8'h4D;
    localparam logic [7:0] SC_END    = 8'h4F;
    localparam logic [7:0] SC_DOWN   = 8'h50;
    localparam logic [7:0] SC_PGDN   = 8'h51;
    localparam logic [7:0] SC_INSERT = 8'h52;
    localparam logic [7:0] SC_DELETE = 8'h53;

    // modifier and lock flag bit positions
    localparam int FL_SCROLL = 0;
    localparam int FL_CAPS   = 1;
    localparam int FL_NUM    = 2;
    localparam int FL_LSHIFT = 3;
    localparam int FL_RSHIFT = 4;
    localparam int FL_LCTRL  = 5;
    localparam int FL_RCTRL  = 6;
    localparam int FL_LALT   = 7;
    localparam int FL_RALT   = 8;
    localparam int FL_W      = 9;

    // event kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SPECIAL = 1'b1;

    // modifier classes
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_SHIFT = 3'd1;
    localparam logic [2:0] CLS_CTRL  = 3'd2;
    localparam logic [2:0] CLS_ALT   = 3'd4;

    // special key ids
    localparam logic [6:0] ID_LCTRL  = 7'd0;
    localparam logic [6:0] ID_LSHIFT = 7'd1;
    localparam logic [6:0] ID_RSHIFT = 7'd2;
    localparam logic [6:0] ID_LALT   = 7'd3;
    localparam logic [6:0] ID_CAPS   = 7'd4;
    localparam logic [6:0] ID_NUM    = 7'd5;
    localparam logic [6:0] ID_SCROLL = 7'd6;
    localparam logic [6:0] ID_RCTRL  = 7'd7;
    localparam logic [6:0] ID_RALT   = 7'd8;
    localparam logic [6:0] ID_ENTER  = 7'd9;
    localparam logic [6:0] ID_PRINT  = 7'd10;
    localparam logic [6:0] ID_SYSREQ = 7'd11;
    localparam logic [6:0] ID_SLASH  = 7'd12;
    localparam logic [6:0] ID_HOME   = 7'd13;
    localparam logic [6:0] ID_UP     = 7'd14;
    localparam logic [6:0] ID_PGUP   = 7'd15;
    localparam logic [6:0] ID_LEFT   = 7'd16;
    localparam logic [6:0] ID_RIGHT  = 7'd17;
    localparam logic [6:0] ID_END    = 7'd18;
    localparam logic [6:0] ID_DOWN   = 7'd19;
    localparam logic [6:0] ID_PGDN   = 7'd20;
    localparam logic [6:0] ID_INSERT = 7'd21;
    localparam logic [6:0] ID_DELETE = 7'd22;
    localparam logic [6:0] ID_PAUSE  = 7'd23;

    // output tdata layout, lowest bit first
    localparam int OUT_CLS_LO  = 0;
    localparam int OUT_CODE_LO = 3;
    localparam int OUT_LED_LO  = 10;
    localparam int OUT_UPD     = 13;
    localparam int OUT_REBOOT  = 14;

    typedef struct packed {
        logic       kind;
        logic [2:0] cls;
        logic [6:0] code;
        logic [2:0] leds;
        logic       upd;
        logic       reboot;
    } t_result;

endpackage

FILE: sv/scancode_set1_key_decoder.sv
// a word held in the input register is decoded into the result register on the master side
// throughput: one word per cycle while no result waits on a stalled master side, set by the
// single decode stage; words that give no result are absorbed without a master-side word
// reset: synchronous active-low i_rst_n clears both valid flags and all modifier and lock
// flags, so the leds read zero and no shift, ctrl or alt is held
// depends on scd_pkg
module scancode_set1_key_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // raw_code[15:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // modifier_class[2:0], key_code[9:3], led_state[12:10], led_update[13],
    // reboot_request[14], zero[15]
    output logic [15:0] o_m_tdata,
    output logic        o_m_tuser   // event_kind[0]
);

    logic                     r_in_valid;
    logic [15:0]              r_in_code;
    logic [scd_pkg::FL_W-1:0] r_flags;
    logic [scd_pkg::FL_W-1:0] n_flags;
    logic                     r_out_valid;
    scd_pkg::t_result         r_out;
    scd_pkg::t_result         n_out;
    logic                     w_has;
    logic                     w_adv;
    logic                     w_ctrl;
    logic                     w_alt;
    logic                     w_shift;
    logic [7:0]               w_pre;
    logic [7:0]               w_sc;

    assign w_pre   = r_in_code[15:8];
    assign w_sc    = r_in_code[7:0];
    assign w_ctrl  = r_flags[scd_pkg::FL_LCTRL]  | r_flags[scd_pkg::FL_RCTRL];
    assign w_alt   = r_flags[scd_pkg::FL_LALT]   | r_flags[scd_pkg::FL_RALT];
    assign w_shift = r_flags[scd_pkg::FL_LSHIFT] | r_flags[scd_pkg::FL_RSHIFT];

    always_comb begin
        n_flags     = r_flags;
        w_has       = 1'b0;
        n_out.kind  = scd_pkg::KIND_SPECIAL;
        n_out.cls   = scd_pkg::CLS_NONE;
        n_out.code  = w_sc[6:0];
        n_out.upd   = 1'b0;
        n_out.reboot = 1'b0;
        unique case (w_pre)
            scd_pkg::PRE_NONE: begin
                if (!w_sc[7]) begin
                    w_has = 1'b1;
                    case (w_sc)
                        scd_pkg::SC_CTRL: begin
                            n_flags[scd_pkg::FL_LCTRL] = 1'b1;
                            n_out.code = scd_pkg::ID_LCTRL;
                        end
                        scd_pkg::SC_LSHIFT: begin
                            n_flags[scd_pkg::FL_LSHIFT] = 1'b1;
                            n_out.code = scd_pkg::ID_LSHIFT;
                        end
                        scd_pkg::SC_RSHIFT: begin
                            n_flags[scd_pkg::FL_RSHIFT] = 1'b1;
                            n_out.code = scd_pkg::ID_RSHIFT;
                        end
                        scd_pkg::SC_ALT: begin
                            n_flags[scd_pkg::FL_LALT] = 1'b1;
                            n_out.code = scd_pkg::ID_LALT;
                        end
                        scd_pkg::SC_CAPS: begin
                            n_flags[scd_pkg::FL_CAPS] = ~r_flags[scd_pkg::FL_CAPS];
                            n_out.code = scd_pkg::ID_CAPS;
                            n_out.upd  = 1'b1;
                        end
                        scd_pkg::SC_NUM: begin
                            n_flags[scd_pkg::FL_NUM] = ~r_flags[scd_pkg::FL_NUM];
                            n_out.code = scd_pkg::ID_NUM;
                            n_out.upd  = 1'b1;
                        end
                        scd_pkg::SC_SCROLL: begin
                            n_flags[scd_pkg::FL_SCROLL] = ~r_flags[scd_pkg::FL_SCROLL];
                            n_out.code = scd_pkg::ID_SCROLL;
                            n_out.upd  = 1'b1;
                        end
                        default: begin
                            // plain character, alt beats ctrl beats shift
                            n_out.kind = scd_pkg::KIND_CHAR;
                            if (w_alt) begin
                                n_out.cls = scd_pkg::CLS_ALT;
                            end else if (w_ctrl) begin
                                n_out.cls = scd_pkg::CLS_CTRL;
                            end else if (w_shift) begin
                                n_out.cls = scd_pkg::CLS_SHIFT;
                            end
                        end
                    endcase
                end else begin
                    // releases only drop held modifiers, never give a word
                    case (w_sc)
                        scd_pkg::SC_CTRL_BRK:   n_flags[scd_pkg::FL_LCTRL]  = 1'b0;
                        scd_pkg::SC_LSHIFT_BRK: n_flags[scd_pkg::FL_LSHIFT] = 1'b0;
                        scd_pkg::SC_RSHIFT_BRK: n_flags[scd_pkg::FL_RSHIFT] = 1'b0;
                        scd_pkg::SC_ALT_BRK:    n_flags[scd_pkg::FL_LALT]   = 1'b0;
                        default: ;
                    endcase
                end
            end
            scd_pkg::PRE_EXT: begin
                w_has = 1'b1;
                case (w_sc)
                    scd_pkg::SC_CTRL: begin
                        n_flags[scd_pkg::FL_RCTRL] = 1'b1;
                        n_out.code = scd_pkg::ID_RCTRL;
                    end
                    scd_pkg::SC_CTRL_BRK: begin
                        n_flags[scd_pkg::FL_RCTRL] = 1'b0;
                        w_has = 1'b0;
                    end
                    scd_pkg::SC_ALT: begin
                        n_flags[scd_pkg::FL_RALT] = 1'b1;
                        n_out.code = scd_pkg::ID_RALT;
                    end
                    scd_pkg::SC_ALT_BRK: begin
                        n_flags[scd_pkg::FL_RALT] = 1'b0;
                        w_has = 1'b0;
                    end
                    scd_pkg::SC_ENTER:  n_out.code = scd_pkg::ID_ENTER;
                    scd_pkg::SC_PRINT:  n_out.code = w_ctrl ? scd_pkg::ID_PRINT
                                                            : scd_pkg::ID_SYSREQ;
                    scd_pkg::SC_SLASH:  n_out.code = scd_pkg::ID_SLASH;
                    scd_pkg::SC_HOME:   n_out.code = scd_pkg::ID_HOME;
                    scd_pkg::SC_UP:     n_out.code = scd_pkg::ID_UP;
                    scd_pkg::SC_PGUP:   n_out.code = scd_pkg::ID_PGUP;
                    scd_pkg::SC_LEFT:   n_out.code = scd_pkg::ID_LEFT;
                    scd_pkg::SC_RIGHT:  n_out.code = scd_pkg::ID_RIGHT;
                    scd_pkg::SC_END:    n_out.code = scd_pkg::ID_END;
                    scd_pkg::SC_DOWN:   n_out.code = scd_pkg::ID_DOWN;
                    scd_pkg::SC_PGDN:   n_out.code = scd_pkg::ID_PGDN;
                    scd_pkg::SC_INSERT: n_out.code = scd_pkg::ID_INSERT;
                    scd_pkg::SC_DELETE: begin
                        n_out.code   = scd_pkg::ID_DELETE;
                        n_out.reboot = w_ctrl & w_alt;
                    end
                    default: w_has = 1'b0;
                endcase
            end
            scd_pkg::PRE_PAUSE: begin
                w_has      = 1'b1;
                n_out.code = scd_pkg::ID_PAUSE;
            end
            default: ;
        endcase
        // leds as they stand after this word
        n_out.leds = {n_flags[scd_pkg::FL_CAPS], n_flags[scd_pkg::FL_NUM],
                      n_flags[scd_pkg::FL_SCROLL]};
    end

    // a word leaves the input register when it gives nothing or the result slot frees up
    assign w_adv      = r_in_valid & (~w_has | ~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_flags <= n_flags;
            end
            if (w_adv && w_has) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_code <= i_s_tdata;
        end
        if (w_adv && w_has) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {1'b0, r_out.reboot, r_out.upd, r_out.leds, r_out.code, r_out.cls};

endmodule

FILE: sv/scd_checker.sv
// scd_checker: port-level checks on the scan code set 1 key decoder
// bound to scancode_set1_key_decoder; depends on scd_pkg
module scd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic [6:0] w_code;
    logic [2:0] w_cls;

    assign w_code = o_m_tdata[scd_pkg::OUT_CODE_LO +: 7];
    assign w_cls  = o_m_tdata[scd_pkg::OUT_CLS_LO +: 3];

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // nothing on the master side right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // only caps, num and scroll ask for an led update
    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[scd_pkg::OUT_UPD] |->
            o_m_tuser == scd_pkg::KIND_SPECIAL &&
            (w_code == scd_pkg::ID_CAPS || w_code == scd_pkg::ID_NUM ||
             w_code == scd_pkg::ID_SCROLL))
        else $error("led update on a key that is not a lock");

    // reboot only with delete
    a_reboot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[scd_pkg::OUT_REBOOT] |->
            o_m_tuser == scd_pkg::KIND_SPECIAL && w_code == scd_pkg::ID_DELETE)
        else $error("reboot request on a key other than delete");

    // special keys carry no modifier class
    a_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == scd_pkg::KIND_SPECIAL |-> w_cls == scd_pkg::CLS_NONE)
        else $error("modifier class on a special key");

endmodule

bind scancode_set1_key_decoder scd_checker u_scd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/tb_scancode_set1_key_decoder.sv
// tb_scancode_set1_key_decoder: self-checking bench for the scan code set 1 key decoder
// predicts every result word from its own copy of the modifier and lock flags
// depends on scd_pkg and scancode_set1_key_decoder
module tb_scancode_set1_key_decoder;

    localparam logic [7:0] PRE_PAUSE_SEQ = 8'hE1;   // not decoded, always dropped
    localparam int         GAP_MAX       = 13;
    localparam int         RANDOM_WORDS  = 730;     // per random phase, two phases

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;     // raw_code[15:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;     // modifier_class[2:0], key_code[9:3], led_state[12:10],
                                // led_update[13], reboot_request[14], zero[15]
    logic        o_m_tuser;     // event_kind[0]

    logic [15:0]              pending_words[$];
    scd_pkg::t_result         expected_events[$];
    logic [scd_pkg::FL_W-1:0] held_flags;
    int                       mismatches;

    // driver and monitor working variables
    bit               src_calm, snk_calm;
    int               src_gap, snk_gap, src_gap_n, snk_gap_n;
    logic             src_valid_n;
    logic [15:0]      src_data_n;
    scd_pkg::t_result want;

    logic [7:0] lock_mod_codes [0:10] = '{scd_pkg::SC_CTRL, scd_pkg::SC_LSHIFT,
        scd_pkg::SC_RSHIFT, scd_pkg::SC_ALT, scd_pkg::SC_CAPS, scd_pkg::SC_NUM,
        scd_pkg::SC_SCROLL, scd_pkg::SC_CTRL_BRK, scd_pkg::SC_LSHIFT_BRK,
        scd_pkg::SC_RSHIFT_BRK, scd_pkg::SC_ALT_BRK};
    logic [7:0] ext_codes [0:16] = '{scd_pkg::SC_CTRL, scd_pkg::SC_CTRL_BRK,
        scd_pkg::SC_ALT, scd_pkg::SC_ALT_BRK, scd_pkg::SC_ENTER, scd_pkg::SC_PRINT,
        scd_pkg::SC_SLASH, scd_pkg::SC_HOME, scd_pkg::SC_UP, scd_pkg::SC_PGUP,
        scd_pkg::SC_LEFT, scd_pkg::SC_RIGHT, scd_pkg::SC_END, scd_pkg::SC_DOWN,
        scd_pkg::SC_PGDN, scd_pkg::SC_INSERT, scd_pkg::SC_DELETE};

    scancode_set1_key_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // updates the flags for one raw word and queues the event it gives, if any
    task automatic decode_scan_word(input logic [15:0] raw);
        logic [7:0]       pre;
        logic [7:0]       sc;
        logic             ctrl_held;
        logic             alt_held;
        scd_pkg::t_result ev;
        bit               gives_event;
        pre         = raw[15:8];
        sc          = raw[7:0];
        ev          = '0;
        ev.kind     = scd_pkg::KIND_SPECIAL;
        gives_event = 1'b0;
        ctrl_held   = held_flags[scd_pkg::FL_LCTRL] | held_flags[scd_pkg::FL_RCTRL];
        alt_held    = held_flags[scd_pkg::FL_LALT] | held_flags[scd_pkg::FL_RALT];
        if (pre == scd_pkg::PRE_NONE) begin
            if (!sc[7]) begin
                gives_event = 1'b1;
                case (sc)
                    scd_pkg::SC_CTRL: begin
                        held_flags[scd_pkg::FL_LCTRL] = 1'b1;
                        ev.code = scd_pkg::ID_LCTRL;
                    end
                    scd_pkg::SC_LSHIFT: begin
                        held_flags[scd_pkg::FL_LSHIFT] = 1'b1;
                        ev.code = scd_pkg::ID_LSHIFT;
                    end
                    scd_pkg::SC_RSHIFT: begin
                        held_flags[scd_pkg::FL_RSHIFT] = 1'b1;
                        ev.code = scd_pkg::ID_RSHIFT;
                    end
                    scd_pkg::SC_ALT: begin
                        held_flags[scd_pkg::FL_LALT] = 1'b1;
                        ev.code = scd_pkg::ID_LALT;
                    end
                    scd_pkg::SC_CAPS: begin
                        held_flags[scd_pkg::FL_CAPS] = !held_flags[scd_pkg::FL_CAPS];
                        ev.code = scd_pkg::ID_CAPS;
                        ev.upd  = 1'b1;
                    end
                    scd_pkg::SC_NUM: begin
                        held_flags[scd_pkg::FL_NUM] = !held_flags[scd_pkg::FL_NUM];
                        ev.code = scd_pkg::ID_NUM;
                        ev.upd  = 1'b1;
                    end
                    scd_pkg::SC_SCROLL: begin
                        held_flags[scd_pkg::FL_SCROLL] = !held_flags[scd_pkg::FL_SCROLL];
                        ev.code = scd_pkg::ID_SCROLL;
                        ev.upd  = 1'b1;
                    end
                    default: begin
                        ev.kind = scd_pkg::KIND_CHAR;
                        ev.code = sc[6:0];
                        // alt beats ctrl, ctrl beats shift
                        if (alt_held)
                            ev.cls = scd_pkg::CLS_ALT;
                        else if (ctrl_held)
                            ev.cls = scd_pkg::CLS_CTRL;
                        else if (held_flags[scd_pkg::FL_LSHIFT] |
                                 held_flags[scd_pkg::FL_RSHIFT])
                            ev.cls = scd_pkg::CLS_SHIFT;
                        else
                            ev.cls = scd_pkg::CLS_NONE;
                    end
                endcase
            end else begin
                case (sc)
                    scd_pkg::SC_CTRL_BRK:   held_flags[scd_pkg::FL_LCTRL]  = 1'b0;
                    scd_pkg::SC_LSHIFT_BRK: held_flags[scd_pkg::FL_LSHIFT] = 1'b0;
                    scd_pkg::SC_RSHIFT_BRK: held_flags[scd_pkg::FL_RSHIFT] = 1'b0;
                    scd_pkg::SC_ALT_BRK:    held_flags[scd_pkg::FL_LALT]   = 1'b0;
                    default: ;
                endcase
            end
        end else if (pre == scd_pkg::PRE_EXT) begin
            gives_event = 1'b1;
            case (sc)
                scd_pkg::SC_CTRL: begin
                    held_flags[scd_pkg::FL_RCTRL] = 1'b1;
                    ev.code = scd_pkg::ID_RCTRL;
                end
                scd_pkg::SC_CTRL_BRK: begin
                    held_flags[scd_pkg::FL_RCTRL] = 1'b0;
                    gives_event = 1'b0;
                end
                scd_pkg::SC_ALT: begin
                    held_flags[scd_pkg::FL_RALT] = 1'b1;
                    ev.code = scd_pkg::ID_RALT;
                end
                scd_pkg::SC_ALT_BRK: begin
                    held_flags[scd_pkg::FL_RALT] = 1'b0;
                    gives_event = 1'b0;
                end
                scd_pkg::SC_ENTER:  ev.code = scd_pkg::ID_ENTER;
                scd_pkg::SC_PRINT:  ev.code = ctrl_held ? scd_pkg::ID_PRINT
                                                        : scd_pkg::ID_SYSREQ;
                scd_pkg::SC_SLASH:  ev.code = scd_pkg::ID_SLASH;
                scd_pkg::SC_HOME:   ev.code = scd_pkg::ID_HOME;
                scd_pkg::SC_UP:     ev.code = scd_pkg::ID_UP;
                scd_pkg::SC_PGUP:   ev.code = scd_pkg::ID_PGUP;
                scd_pkg::SC_LEFT:   ev.code = scd_pkg::ID_LEFT;
                scd_pkg::SC_RIGHT:  ev.code = scd_pkg::ID_RIGHT;
                scd_pkg::SC_END:    ev.code = scd_pkg::ID_END;
                scd_pkg::SC_DOWN:   ev.code = scd_pkg::ID_DOWN;
                scd_pkg::SC_PGDN:   ev.code = scd_pkg::ID_PGDN;
                scd_pkg::SC_INSERT: ev.code = scd_pkg::ID_INSERT;
                scd_pkg::SC_DELETE: begin
                    ev.code   = scd_pkg::ID_DELETE;
                    ev.reboot = ctrl_held & alt_held;
                end
                default: gives_event = 1'b0;
            endcase
        end else if (pre == scd_pkg::PRE_PAUSE) begin
            gives_event = 1'b1;
            ev.code = scd_pkg::ID_PAUSE;
        end
        if (gives_event) begin
            ev.leds = {held_flags[scd_pkg::FL_CAPS], held_flags[scd_pkg::FL_NUM],
                       held_flags[scd_pkg::FL_SCROLL]};
            expected_events.push_back(ev);
        end
    endtask

    // plain, modifier, lock and extended codes, with some noise; the noise words do not
    // count towards n, though some of them still give a result
    task automatic queue_random_words(input int n);
        int          taken;
        int          pick;
        bit          counts;
        logic [15:0] w;
        taken = 0;
        while (taken < n) begin
            pick   = $urandom_range(0, 99);
            counts = 1'b1;
            if (pick < 35) begin
                w = {scd_pkg::PRE_NONE, 1'b0, 7'($urandom_range(0, 127))};
            end else if (pick < 52) begin
                w = {scd_pkg::PRE_NONE, lock_mod_codes[$urandom_range(0, 10)]};
            end else if (pick < 72) begin
                w = {scd_pkg::PRE_EXT, ext_codes[$urandom_range(0, 16)]};
            end else if (pick < 80) begin
                w = {scd_pkg::PRE_NONE, 1'b1, 7'($urandom_range(0, 127))};
                counts = 1'b0;
            end else if (pick < 85) begin
                w = {scd_pkg::PRE_EXT, 8'($urandom_range(0, 255))};
                counts = 1'b0;
            end else if (pick < 90) begin
                w = {scd_pkg::PRE_PAUSE, 8'($urandom_range(0, 255))};
            end else if (pick < 94) begin
                w = {PRE_PAUSE_SEQ, 8'($urandom_range(0, 255))};
                counts = 1'b0;
            end else begin
                w = 16'($urandom_range(0, 65535));
                counts = 1'b0;
            end
            pending_words.push_back(w);
            if (counts)
                taken++;
        end
    endtask

    // sampled at the falling edge so the driver has settled
    task automatic wait_for_drain();
        while (pending_words.size() != 0 || i_s_tvalid || expected_events.size() != 0)
            @(negedge i_clk);
    endtask

    // slave side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap    <= 0;
        end else begin
            src_valid_n = i_s_tvalid;
            src_data_n  = i_s_tdata;
            src_gap_n   = src_gap;
            if (i_s_tvalid && o_s_tready) begin
                decode_scan_word(i_s_tdata);
                src_valid_n = 1'b0;
            end
            if (!src_valid_n) begin
                if (src_gap_n > 0) begin
                    src_gap_n--;
                end else if (pending_words.size() != 0) begin
                    src_data_n  = pending_words.pop_front();
                    src_valid_n = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        src_calm = !src_calm;
                    src_gap_n = src_calm ? 0 : $urandom_range(0, GAP_MAX);
                end
            end
            i_s_tvalid <= src_valid_n;
            i_s_tdata  <= src_data_n;
            src_gap    <= src_gap_n;
        end
    end

    // master side monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_gap    <= 0;
        end else begin
            snk_gap_n = snk_gap;
            if (o_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("result word with nothing expected: tdata %h tuser %b",
                           o_m_tdata, o_m_tuser);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_m_tuser !== want.kind) begin
                        $error("event_kind expected %0d got %0d", want.kind, o_m_tuser);
                        mismatches++;
                    end
                    if (o_m_tdata[scd_pkg::OUT_CLS_LO +: 3] !== want.cls) begin
                        $error("modifier_class expected %0d got %0d", want.cls,
                               o_m_tdata[scd_pkg::OUT_CLS_LO +: 3]);
                        mismatches++;
                    end
                    if (o_m_tdata[scd_pkg::OUT_CODE_LO +: 7] !== want.code) begin
                        $error("key_code expected %0d got %0d", want.code,
                               o_m_tdata[scd_pkg::OUT_CODE_LO +: 7]);
                        mismatches++;
                    end
                    if (o_m_tdata[scd_pkg::OUT_LED_LO +: 3] !== want.leds) begin
                        $error("led_state expected %0d got %0d", want.leds,
                               o_m_tdata[scd_pkg::OUT_LED_LO +: 3]);
                        mismatches++;
                    end
                    if (o_m_tdata[scd_pkg::OUT_UPD] !== want.upd) begin
                        $error("led_update expected %0d got %0d", want.upd,
                               o_m_tdata[scd_pkg::OUT_UPD]);
                        mismatches++;
                    end
                    if (o_m_tdata[scd_pkg::OUT_REBOOT] !== want.reboot) begin
                        $error("reboot_request expected %0d got %0d", want.reboot,
                               o_m_tdata[scd_pkg::OUT_REBOOT]);
                        mismatches++;
                    end
                    if (o_m_tdata[15] !== 1'b0) begin
                        $error("padding bit expected 0 got %0d", o_m_tdata[15]);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    snk_calm = !snk_calm;
                snk_gap_n = snk_calm ? 0 : $urandom_range(0, GAP_MAX);
            end else if (snk_gap_n > 0) begin
                snk_gap_n--;
            end
            i_m_tready <= (snk_gap_n == 0);
            snk_gap    <= snk_gap_n;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        held_flags = '0;
        mismatches = 0;
        src_calm   = 1'b0;
        snk_calm   = 1'b0;

        // directed: class priority, print and reboot with modifiers, locks, drops
        pending_words = '{
            {scd_pkg::PRE_NONE, 8'h00}, {scd_pkg::PRE_NONE, 8'h7F},
            {scd_pkg::PRE_NONE, scd_pkg::SC_LSHIFT}, {scd_pkg::PRE_NONE, 8'h10},
            {scd_pkg::PRE_NONE, scd_pkg::SC_CTRL}, {scd_pkg::PRE_NONE, 8'h1E},
            {scd_pkg::PRE_EXT, scd_pkg::SC_PRINT},
            {scd_pkg::PRE_NONE, scd_pkg::SC_ALT}, {scd_pkg::PRE_NONE, 8'h2C},
            {scd_pkg::PRE_EXT, scd_pkg::SC_DELETE},
            {scd_pkg::PRE_NONE, scd_pkg::SC_LSHIFT_BRK},
            {scd_pkg::PRE_NONE, scd_pkg::SC_CTRL_BRK},
            {scd_pkg::PRE_NONE, scd_pkg::SC_ALT_BRK},
            {scd_pkg::PRE_EXT, scd_pkg::SC_PRINT},
            {scd_pkg::PRE_NONE, scd_pkg::SC_CAPS}, {scd_pkg::PRE_NONE, scd_pkg::SC_NUM},
            {scd_pkg::PRE_NONE, scd_pkg::SC_SCROLL},
            {scd_pkg::PRE_NONE, 8'hFF}, {scd_pkg::PRE_NONE, scd_pkg::SC_RSHIFT},
            {scd_pkg::PRE_NONE, scd_pkg::SC_RSHIFT_BRK},
            {scd_pkg::PRE_EXT, scd_pkg::SC_CTRL}, {scd_pkg::PRE_EXT, scd_pkg::SC_ALT},
            {scd_pkg::PRE_EXT, scd_pkg::SC_DELETE},
            {scd_pkg::PRE_EXT, scd_pkg::SC_CTRL_BRK},
            {scd_pkg::PRE_EXT, scd_pkg::SC_ALT_BRK}, {scd_pkg::PRE_EXT, 8'hFF},
            {PRE_PAUSE_SEQ, scd_pkg::SC_CTRL}, {scd_pkg::PRE_PAUSE, 8'h00},
            {scd_pkg::PRE_PAUSE, 8'hFF},
            16'h1234, {scd_pkg::PRE_NONE, scd_pkg::SC_CAPS}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender holds off until the block has emptied between phases
        wait_for_drain();
        queue_random_words(RANDOM_WORDS);
        wait_for_drain();
        queue_random_words(RANDOM_WORDS);
        wait_for_drain();

        // keep running to catch a stray result word
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS scancode_set1_key_decoder");
        end else begin
            $display("FAIL scancode_set1_key_decoder");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("FAIL scancode_set1_key_decoder");
        $finish;
    end

endmodule

FILE: files.f
sv/scd_pkg.sv
sv/scancode_set1_key_decoder.sv
sv/scd_checker.sv
tb/tb_scancode_set1_key_decoder.sv
